### hw/rtl/limit_order_book_matcher_assert.svh
// assertion macros used by the order book controller
// no dependencies; each macro expands to one concurrent assertion
`ifndef LIMIT_ORDER_BOOK_MATCHER_ASSERT_SVH
`define LIMIT_ORDER_BOOK_MATCHER_ASSERT_SVH

// property must hold at every rising clock edge outside reset
`define LOB_ASSERT_ALWAYS(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("order book assertion failed");

// consequent must hold in the same cycle as the antecedent
`define LOB_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("order book assertion failed");

`endif

### hw/rtl/lob_pkg.sv
// shared constants, codes and command/status types of the order book
// no dependencies
`default_nettype none
package lob_pkg;
   localparam int ORDER_SLOTS = 32;
   localparam int SLOT_W = $clog2(ORDER_SLOTS);
   localparam int ROUND_W = $clog2(ORDER_SLOTS + 1);

   localparam logic [1:0] OP_ADD = 2'd0;
   localparam logic [1:0] OP_CANCEL = 2'd1;
   localparam logic [1:0] OP_BEST_SELL = 2'd2;
   localparam logic [1:0] OP_BEST_BUY = 2'd3;

   localparam logic [2:0] ST_FILL = 3'd0;
   localparam logic [2:0] ST_RESTED = 3'd1;
   localparam logic [2:0] ST_FULL_FILL = 3'd2;
   localparam logic [2:0] ST_DROPPED = 3'd3;
   localparam logic [2:0] ST_CANCELLED = 3'd4;
   localparam logic [2:0] ST_NOT_FOUND = 3'd5;
   localparam logic [2:0] ST_BEST = 3'd6;
   localparam logic [2:0] ST_NONE = 3'd7;

   typedef struct packed {
      logic load;
      logic scan_clear;
      logic scan_en;
      logic [SLOT_W-1:0] scan_idx;
      logic emit_fill;
      logic emit_close;
      logic emit_single;
   } cmd_type;

   typedef struct packed {
      logic req_add;
      logic req_skip;
      logic op_add;
      logic have;
      logic rem_zero;
      logic rsp_free;
   } stat_type;
endpackage
`default_nettype wire

### hw/rtl/limit_order_book_matcher.sv
// top level of the price-time priority order book matcher
// depends on lob_pkg, lob_ctrl and lob_dp
//
//   channel   direction  handshake              payload
//   req       in         req_valid/req_ready    operation, id, side, price, quantity
//   rsp       out        rsp_valid/rsp_ready    status, id, side, price, quantity, last
//
// one transaction at a time; each best-entry scan walks all 32 slots, one per cycle
// an add scans again after each fill while quantity remains, for at most 32 fills, then
//   closes with one result that reports it fully filled, rested or dropped
// cancel and queries take one scan and give a single result; zero-quantity adds give none
// reset is synchronous and empties the book; a stalled rsp holds the next result back
`default_nettype none
module limit_order_book_matcher (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic req_ready,
   input  wire logic [1:0] req_operation,
   input  wire logic [31:0] req_order_id,
   input  wire logic req_buy_or_sell,
   input  wire logic [31:0] req_limit_price,
   input  wire logic [31:0] req_quantity,
   output logic rsp_valid,
   input  wire logic rsp_ready,
   output logic [2:0] rsp_status,
   output logic [31:0] rsp_result_id,
   output logic rsp_result_side,
   output logic [31:0] rsp_result_price,
   output logic [31:0] rsp_result_quantity,
   output logic rsp_last_of_run
);
   import lob_pkg::*;

   cmd_type cmd;
   stat_type stat;

   lob_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .stat(stat),
      .cmd(cmd)
   );

   lob_dp u_dp (
      .clock(clock),
      .reset(reset),
      .cmd(cmd),
      .stat(stat),
      .req_operation(req_operation),
      .req_order_id(req_order_id),
      .req_buy_or_sell(req_buy_or_sell),
      .req_limit_price(req_limit_price),
      .req_quantity(req_quantity),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_status(rsp_status),
      .rsp_result_id(rsp_result_id),
      .rsp_result_side(rsp_result_side),
      .rsp_result_price(rsp_result_price),
      .rsp_result_quantity(rsp_result_quantity),
      .rsp_last_of_run(rsp_last_of_run)
   );
endmodule
`default_nettype wire

### hw/rtl/lob_ctrl.sv
// controller of the order book: sequences scans, fills, closing and single results
// depends on lob_pkg and limit_order_book_matcher_assert.svh
`default_nettype none
`include "limit_order_book_matcher_assert.svh"
module lob_ctrl (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic req_ready,
   input  wire lob_pkg::stat_type stat,
   output lob_pkg::cmd_type cmd
);
   import lob_pkg::*;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_SCAN = 3'd1;
   localparam logic [2:0] S_DECIDE = 3'd2;
   localparam logic [2:0] S_CHECK = 3'd3;
   localparam logic [2:0] S_CLOSE = 3'd4;

   logic [2:0] state_ff, state_in;
   logic [SLOT_W-1:0] idx_ff, idx_in;
   logic [ROUND_W-1:0] rounds_ff, rounds_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      idx_in = idx_ff;
      rounds_in = rounds_ff;
      cmd = '0;
      cmd.scan_idx = idx_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               if (!stat.req_skip) begin
                  cmd.scan_clear = 1'b1;
                  idx_in = '0;
                  rounds_in = '0;
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            cmd.scan_en = 1'b1;
            idx_in = idx_ff + 1'b1;
            if (idx_ff == SLOT_W'(ORDER_SLOTS - 1)) begin
               idx_in = '0;
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (stat.op_add) begin
               if (!stat.have) begin
                  state_in = S_CLOSE;
               end else if (stat.rsp_free) begin
                  cmd.emit_fill = 1'b1;
                  rounds_in = rounds_ff + 1'b1;
                  state_in = S_CHECK;
               end
            end else if (stat.rsp_free) begin
               cmd.emit_single = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_CHECK: begin
            if (!stat.rem_zero && rounds_ff < ROUND_W'(ORDER_SLOTS)) begin
               cmd.scan_clear = 1'b1;
               state_in = S_SCAN;
            end else begin
               state_in = S_CLOSE;
            end
         end
         S_CLOSE: begin
            if (stat.rsp_free) begin
               cmd.emit_close = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         idx_ff <= '0;
         rounds_ff <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff <= idx_in;
         rounds_ff <= rounds_in;
      end
   end

   `LOB_ASSERT_ALWAYS(a_one_emit, clock, reset,
      $onehot0({cmd.emit_fill, cmd.emit_close, cmd.emit_single}))
   `LOB_ASSERT_IMPLY(a_emit_free, clock, reset,
      cmd.emit_fill || cmd.emit_close || cmd.emit_single, stat.rsp_free)
   `LOB_ASSERT_IMPLY(a_fill_has_best, clock, reset, cmd.emit_fill, stat.have)
   `LOB_ASSERT_ALWAYS(a_rounds_bound, clock, reset, rounds_ff <= ROUND_W'(ORDER_SLOTS))
endmodule
`default_nettype wire

### hw/rtl/lob_dp.sv
// datapath of the order book: slot registers, best-entry scan, result register
// depends on lob_pkg
`default_nettype none
module lob_dp (
   input  wire logic clock,
   input  wire logic reset,
   input  wire lob_pkg::cmd_type cmd,
   output lob_pkg::stat_type stat,
   input  wire logic [1:0] req_operation,
   input  wire logic [31:0] req_order_id,
   input  wire logic req_buy_or_sell,
   input  wire logic [31:0] req_limit_price,
   input  wire logic [31:0] req_quantity,
   output logic rsp_valid,
   input  wire logic rsp_ready,
   output logic [2:0] rsp_status,
   output logic [31:0] rsp_result_id,
   output logic rsp_result_side,
   output logic [31:0] rsp_result_price,
   output logic [31:0] rsp_result_quantity,
   output logic rsp_last_of_run
);
   import lob_pkg::*;

   logic [ORDER_SLOTS-1:0] valid_ff;
   logic [31:0] id_ff [ORDER_SLOTS];
   logic side_ff [ORDER_SLOTS];
   logic [31:0] price_ff [ORDER_SLOTS];
   logic [31:0] qty_ff [ORDER_SLOTS];
   logic [31:0] arrival_ff [ORDER_SLOTS];
   logic [31:0] counter_ff;

   // latched transaction
   logic [1:0] op_ff;
   logic [31:0] oid_ff, lim_ff, rem_ff, stamp_ff;
   logic oside_ff;

   // running best
   logic have_ff;
   logic [SLOT_W-1:0] bidx_ff;
   logic [31:0] bid_ff, bprice_ff, bqty_ff, bage_ff;
   logic bside_ff;

   logic rsp_valid_ff;
   logic [2:0] st_ff;
   logic [31:0] rid_ff, rprice_ff, rqty_ff;
   logic rside_ff, rlast_ff;

   logic want_side;
   logic [31:0] want_lim;
   logic [31:0] cur_age;
   logic cand, better;
   logic [31:0] amt, left;
   logic free_found;
   logic [SLOT_W-1:0] free_idx;

   always_comb begin
      case (op_ff)
         OP_ADD: begin
            want_side = ~oside_ff;
            want_lim = lim_ff;
         end
         OP_BEST_SELL: begin
            want_side = 1'b1;
            want_lim = 32'hFFFF_FFFF;
         end
         default: begin
            want_side = 1'b0;
            want_lim = 32'h0;
         end
      endcase
   end

   always_comb begin
      cur_age = counter_ff - arrival_ff[cmd.scan_idx];
      if (op_ff == OP_CANCEL) begin
         cand = valid_ff[cmd.scan_idx] && (id_ff[cmd.scan_idx] == oid_ff);
         better = !have_ff || (cur_age > bage_ff);
      end else begin
         cand = valid_ff[cmd.scan_idx] && (side_ff[cmd.scan_idx] == want_side) &&
                (want_side ? (price_ff[cmd.scan_idx] <= want_lim)
                           : (price_ff[cmd.scan_idx] >= want_lim));
         if (!have_ff)
            better = 1'b1;
         else if (price_ff[cmd.scan_idx] == bprice_ff)
            better = cur_age > bage_ff;
         else
            better = want_side ? (price_ff[cmd.scan_idx] < bprice_ff)
                               : (price_ff[cmd.scan_idx] > bprice_ff);
      end
   end

   assign amt = (rem_ff < bqty_ff) ? rem_ff : bqty_ff;
   assign left = bqty_ff - amt;

   // lowest free slot
   always_comb begin
      free_found = 1'b0;
      free_idx = '0;
      for (int i = ORDER_SLOTS - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_found = 1'b1;
            free_idx = SLOT_W'(i);
         end
      end
   end

   always_comb begin
      stat.req_add = (req_operation == OP_ADD);
      stat.req_skip = (req_operation == OP_ADD) && (req_quantity == 32'h0);
      stat.op_add = (op_ff == OP_ADD);
      stat.have = have_ff;
      stat.rem_zero = (rem_ff == 32'h0);
      stat.rsp_free = !rsp_valid_ff || rsp_ready;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         counter_ff <= '0;
         have_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.emit_fill || cmd.emit_close || cmd.emit_single)
            rsp_valid_ff <= 1'b1;
         else if (rsp_valid_ff && rsp_ready)
            rsp_valid_ff <= 1'b0;
         if (cmd.load && stat.req_add && !stat.req_skip)
            counter_ff <= counter_ff + 32'd1;
         if (cmd.scan_clear)
            have_ff <= 1'b0;
         if (cmd.scan_en && cand && better)
            have_ff <= 1'b1;
         if (cmd.emit_fill) begin
            if (left == 32'h0)
               valid_ff[bidx_ff] <= 1'b0;
         end
         if (cmd.emit_close) begin
            if (rem_ff != 32'h0 && free_found)
               valid_ff[free_idx] <= 1'b1;
         end
         if (cmd.emit_single) begin
            if (op_ff == OP_CANCEL && have_ff)
               valid_ff[bidx_ff] <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff <= req_operation;
         oid_ff <= req_order_id;
         oside_ff <= req_buy_or_sell;
         lim_ff <= req_limit_price;
         rem_ff <= req_quantity;
         stamp_ff <= counter_ff;
      end
      if (cmd.scan_en && cand && better) begin
         bidx_ff <= cmd.scan_idx;
         bid_ff <= id_ff[cmd.scan_idx];
         bside_ff <= side_ff[cmd.scan_idx];
         bprice_ff <= price_ff[cmd.scan_idx];
         bqty_ff <= qty_ff[cmd.scan_idx];
         bage_ff <= cur_age;
      end
      if (cmd.emit_fill) begin
         qty_ff[bidx_ff] <= left;
         rem_ff <= rem_ff - amt;
         st_ff <= ST_FILL;
         rid_ff <= bid_ff;
         rside_ff <= bside_ff;
         rprice_ff <= bprice_ff;
         rqty_ff <= amt;
         rlast_ff <= 1'b0;
      end
      if (cmd.emit_close) begin
         rid_ff <= oid_ff;
         rside_ff <= oside_ff;
         rprice_ff <= lim_ff;
         rqty_ff <= rem_ff;
         rlast_ff <= 1'b1;
         if (rem_ff == 32'h0) begin
            st_ff <= ST_FULL_FILL;
         end else if (free_found) begin
            st_ff <= ST_RESTED;
            id_ff[free_idx] <= oid_ff;
            side_ff[free_idx] <= oside_ff;
            price_ff[free_idx] <= lim_ff;
            qty_ff[free_idx] <= rem_ff;
            arrival_ff[free_idx] <= stamp_ff;
         end else begin
            st_ff <= ST_DROPPED;
         end
      end
      if (cmd.emit_single) begin
         rlast_ff <= 1'b1;
         if (have_ff) begin
            st_ff <= (op_ff == OP_CANCEL) ? ST_CANCELLED : ST_BEST;
            rid_ff <= bid_ff;
            rside_ff <= bside_ff;
            rprice_ff <= bprice_ff;
            rqty_ff <= bqty_ff;
         end else begin
            st_ff <= (op_ff == OP_CANCEL) ? ST_NOT_FOUND : ST_NONE;
            rid_ff <= (op_ff == OP_CANCEL) ? oid_ff : 32'h0;
            rside_ff <= 1'b0;
            rprice_ff <= 32'h0;
            rqty_ff <= 32'h0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = st_ff;
   assign rsp_result_id = rid_ff;
   assign rsp_result_side = rside_ff;
   assign rsp_result_price = rprice_ff;
   assign rsp_result_quantity = rqty_ff;
   assign rsp_last_of_run = rlast_ff;
endmodule
`default_nettype wire
